// ----- src/i2c_master_register_access_macros.svh -----
// ----------------------------------------------------------------------------
// i2c master register access assertion macros
// Shared concurrent assertion forms used by the sequencer engine module.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_ACCESS_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_MACROS_SVH

// same-cycle implication, checked outside reset
`define I2CM_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cm same-cycle check failed");

// next-cycle implication, checked outside reset
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cm next-cycle check failed");

`endif

// ----- src/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types, codes and reset constants shared by the i2c master controller.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // default width of the bus timing counter
  localparam int TIMER_WIDTH_DEFAULT = 16;

  // configuration port
  localparam int CFG_DATA_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_HIGH_TIME        = 3'd0,
    CFG_LOW_TIME         = 3'd1,
    CFG_START_SETUP_TIME = 3'd2,
    CFG_DATA_SETUP_TIME  = 3'd3,
    CFG_DATA_HOLD_TIME   = 3'd4,
    CFG_VALID_TIME       = 3'd5,
    CFG_CLAIM_TIMEOUT    = 3'd6
  } cfg_index_t;

  // register reset values, in ticks
  localparam logic [15:0] RST_HIGH_TIME        = 16'd40;
  localparam logic [15:0] RST_LOW_TIME         = 16'd47;
  localparam logic [15:0] RST_START_SETUP_TIME = 16'd47;
  localparam logic [15:0] RST_DATA_SETUP_TIME  = 16'd3;
  localparam logic [15:0] RST_DATA_HOLD_TIME   = 16'd50;
  localparam logic [15:0] RST_VALID_TIME       = 16'd35;
  localparam logic [15:0] RST_CLAIM_TIMEOUT    = 16'd100;

  // command codes
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_READ2 = 2'd3;

  // error flag bit positions
  localparam int ERR_NACK_BIT  = 0;
  localparam int ERR_CLAIM_BIT = 1;
  localparam int ERR_ARB_BIT   = 2;

  // bus sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_CLAIM_BUF  = 5'd1,
    PH_CLAIM_POLL = 5'd2,
    PH_ST_SETUP   = 5'd3,
    PH_ST_HOLD    = 5'd4,
    PH_TX_LOW     = 5'd5,
    PH_TX_SETUP   = 5'd6,
    PH_TX_HIGH    = 5'd7,
    PH_TX_HOLD    = 5'd8,
    PH_ACK_VALID  = 5'd9,
    PH_ACK_HIGH   = 5'd10,
    PH_RX_LOW     = 5'd11,
    PH_RX_HIGH    = 5'd12,
    PH_RX_LOWBIT  = 5'd13,
    PH_RA_SETUP   = 5'd14,
    PH_RA_HIGH    = 5'd15,
    PH_RA_LOW     = 5'd16,
    PH_SP_RISE    = 5'd17,
    PH_SP_HOLD    = 5'd18,
    PH_SP_BUF     = 5'd19
  } phase_t;

  // bus timing registers
  typedef struct packed {
    logic [15:0] high_time;
    logic [15:0] low_time;
    logic [15:0] start_setup_time;
    logic [15:0] data_setup_time;
    logic [15:0] data_hold_time;
    logic [15:0] valid_time;
    logic [15:0] claim_timeout;
  } timing_t;

  // one tick of input
  typedef struct packed {
    logic [1:0] command;
    logic [6:0] device_addr;
    logic [7:0] reg_offset;
    logic [7:0] write_data;
    logic       sda_in;
    logic       scl_in;
  } cmd_item_t;

  // one tick of result
  typedef struct packed {
    logic        scl_drive;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
    logic        err_nack;
    logic        err_claim;
    logic        err_arbitration;
  } res_item_t;

endpackage

// ----- src/i2cm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// i2cm_cfg_regs
// Bus timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
module i2cm_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [i2cm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output i2cm_pkg::timing_t                    timing
);
  import i2cm_pkg::*;

  // register writes, out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.high_time        <= RST_HIGH_TIME;
      timing.low_time         <= RST_LOW_TIME;
      timing.start_setup_time <= RST_START_SETUP_TIME;
      timing.data_setup_time  <= RST_DATA_SETUP_TIME;
      timing.data_hold_time   <= RST_DATA_HOLD_TIME;
      timing.valid_time       <= RST_VALID_TIME;
      timing.claim_timeout    <= RST_CLAIM_TIMEOUT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_HIGH_TIME:        timing.high_time        <= cfg_data;
        CFG_LOW_TIME:         timing.low_time         <= cfg_data;
        CFG_START_SETUP_TIME: timing.start_setup_time <= cfg_data;
        CFG_DATA_SETUP_TIME:  timing.data_setup_time  <= cfg_data;
        CFG_DATA_HOLD_TIME:   timing.data_hold_time   <= cfg_data;
        CFG_VALID_TIME:       timing.valid_time       <= cfg_data;
        CFG_CLAIM_TIMEOUT:    timing.claim_timeout    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/i2cm_engine.sv -----
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer state and the single-tick step logic that advances it.
// ----------------------------------------------------------------------------
`include "i2c_master_register_access_macros.svh"

module i2cm_engine #(
  parameter int TIMER_WIDTH = i2cm_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step_en,
  input  i2cm_pkg::cmd_item_t item,
  input  i2cm_pkg::timing_t   timing,
  output i2cm_pkg::res_item_t result
);
  import i2cm_pkg::*;

  localparam int CmpWidth = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  typedef enum logic [1:0] {
    ACT_TX,
    ACT_RESTART,
    ACT_RX,
    ACT_STOP
  } step_act_t;

  // sequencer state
  phase_t                 phase, phase_next;
  logic [TIMER_WIDTH-1:0] wait_count, wait_count_next;
  logic [3:0]             bit_count, bit_count_next;
  logic [2:0]             byte_step, byte_step_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic [15:0]            gathered_data, gathered_data_next;
  logic [1:0]             held_command, held_command_next;
  logic [6:0]             held_slave, held_slave_next;
  logic [7:0]             held_register, held_register_next;
  logic [7:0]             held_write_byte, held_write_byte_next;
  logic [2:0]             error_bits, error_bits_next;
  logic                   scl_out, scl_out_next;
  logic                   sda_out, sda_out_next;
  logic                   done_next;

  logic [15:0]            delay_sel;
  logic                   reached;
  logic [TIMER_WIDTH-1:0] wait_inc;
  logic [2:0]             step_inc;
  step_act_t              step_act;
  logic                   take_step;

  // byte sent at a given step of the transaction
  function automatic logic [7:0] tx_byte(input logic [2:0] step, input logic [1:0] cmd,
                                         input logic [6:0] slave, input logic [7:0] regs,
                                         input logic [7:0] wbyte);
    logic [7:0] b;
    if (step == 3'd0) begin
      b = {slave, 1'b0};
    end else if (step == 3'd1) begin
      b = regs;
    end else if (cmd == CMD_WRITE) begin
      b = wbyte;
    end else begin
      b = {slave, 1'b1};
    end
    return b;
  endfunction

  // delay register for the current phase
  always_comb begin
    unique case (phase)
      PH_CLAIM_BUF, PH_TX_LOW, PH_RX_LOW, PH_RX_LOWBIT,
      PH_RA_LOW, PH_SP_BUF:                          delay_sel = timing.low_time;
      PH_CLAIM_POLL:                                 delay_sel = timing.claim_timeout;
      PH_ST_SETUP:                                   delay_sel = timing.start_setup_time;
      PH_ST_HOLD, PH_TX_HIGH, PH_ACK_HIGH,
      PH_RA_HIGH, PH_SP_HOLD:                        delay_sel = timing.high_time;
      PH_TX_SETUP, PH_RA_SETUP:                      delay_sel = timing.data_setup_time;
      PH_TX_HOLD:                                    delay_sel = timing.data_hold_time;
      PH_ACK_VALID, PH_RX_HIGH:                      delay_sel = timing.valid_time;
      default:                                       delay_sel = '0;
    endcase
  end

  // delay reached; a delay beyond the timer saturates at the all-ones count
  assign reached  = (CmpWidth'(wait_count) >= CmpWidth'(delay_sel)) || (&wait_count);
  assign wait_inc = wait_count + TIMER_WIDTH'(1);

  // what follows an acknowledged or received byte
  assign step_inc = byte_step + 3'd1;
  always_comb begin
    if (held_command == CMD_WRITE) begin
      step_act = (step_inc <= 3'd2) ? ACT_TX : ACT_STOP;
    end else if (step_inc == 3'd1) begin
      step_act = ACT_TX;
    end else if (step_inc == 3'd2) begin
      step_act = ACT_RESTART;
    end else if (step_inc == 3'd3 || (step_inc == 3'd4 && held_command == CMD_READ2)) begin
      step_act = ACT_RX;
    end else begin
      step_act = ACT_STOP;
    end
  end

  // next state
  always_comb begin
    phase_next           = phase;
    wait_count_next      = wait_count;
    bit_count_next       = bit_count;
    byte_step_next       = byte_step;
    shift_byte_next      = shift_byte;
    gathered_data_next   = gathered_data;
    held_command_next    = held_command;
    held_slave_next      = held_slave;
    held_register_next   = held_register;
    held_write_byte_next = held_write_byte;
    error_bits_next      = error_bits;
    scl_out_next         = scl_out;
    sda_out_next         = sda_out;
    done_next            = 1'b0;
    take_step            = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        scl_out_next = 1'b1;
        sda_out_next = 1'b1;
        if (item.command != CMD_NONE) begin
          held_command_next    = item.command;
          held_slave_next      = item.device_addr;
          held_register_next   = item.reg_offset;
          held_write_byte_next = item.write_data;
          if (item.command != CMD_WRITE) gathered_data_next = '0;
          byte_step_next  = '0;
          bit_count_next  = '0;
          wait_count_next = '0;
          phase_next      = PH_CLAIM_BUF;
        end
      end
      PH_CLAIM_BUF: begin
        if (reached) begin
          wait_count_next = '0;
          phase_next      = PH_CLAIM_POLL;
        end else begin
          wait_count_next = wait_inc;
        end
      end
      PH_CLAIM_POLL: begin
        if (item.sda_in && item.scl_in) begin
          wait_count_next = '0;
          phase_next      = PH_ST_SETUP;
        end else if (reached) begin
          error_bits_next[ERR_CLAIM_BIT] = 1'b1;
          wait_count_next = '0;
          phase_next      = PH_ST_SETUP;
        end else begin
          wait_count_next = wait_inc;
        end
      end
      PH_ST_SETUP: begin
        if (reached) begin
          wait_count_next = '0;
          sda_out_next    = 1'b0;
          phase_next      = PH_ST_HOLD;
        end else begin
          wait_count_next = wait_inc;
        end
      end
      PH_ST_HOLD: begin
        if (reached) begin
          wait_count_next = '0;
          scl_out_next    = 1'b0;
          shift_byte_next = tx_byte(byte_step, held_command, held_slave,
                                    held_register, held_write_byte);
          bit_count_next  = '0;
          phase_next      = PH_TX_LOW;
        end else begin
          wait_count_next = wait_inc;
        end
      end
      PH_TX_LOW: begin
        if (reached) begin
          wait_count_next = '0;
          sda_out_next    = shift_byte[7];
          phase_next      = PH_TX_SETUP;
        end else begin
          wait_count_next = wait_inc;
        end
      end
      PH_TX_SETUP: begin
        if (reached) begin
          wait_count_next = '0;
          scl_out_next    = 1'b1;
          phase_next      = PH_TX_HIGH;
        end else begin
          wait_count_next = wait_inc;
        end
      end
      PH_TX_HIGH: begin
        // arbitration check on the first tick of the high phase
        if (wait_count == '0 && shift_byte[7] && !item.sda_in) begin
          error_bits_next[ERR_ARB_BIT] = 1'b1;
        end
        if (!reached) begin
          wait_count_next = wait_inc;
        end else if (item.scl_in) begin
          wait_count_next = '0;
          scl_out_next    = 1'b0;
          shift_byte_next = {shift_byte[6:0], 1'b0};
          bit_count_next  = bit_count + 4'd1;
          phase_next      = PH_TX_HOLD;
        end
      end
      PH_TX_HOLD: begin
        if (reached) begin
          wait_count_next = '0;
          if (bit_count[3]) begin
            sda_out_next = 1'b1;
            scl_out_next = 1'b1;
            phase_next   = PH_ACK_VALID;
          end else begin
            sda_out_next = shift_byte[7];
            phase_next   = PH_TX_SETUP;
          end
        end else begin
          wait_count_next = wait_inc;
        end
      end
      PH_ACK_VALID: begin
        if (!reached) begin
          wait_count_next = wait_inc;
        end else if (item.scl_in) begin
          wait_count_next = '0;
          if (item.sda_in) error_bits_next[ERR_NACK_BIT] = 1'b1;
          phase_next = PH_ACK_HIGH;
        end
      end
      PH_ACK_HIGH: begin
        if (reached) begin
          wait_count_next = '0;
          scl_out_next    = 1'b0;
          sda_out_next    = 1'b0;
          take_step       = 1'b1;
        end else begin
          wait_count_next = wait_inc;
        end
      end
      PH_RX_LOW: begin
        if (reached) begin
          wait_count_next = '0;
          sda_out_next    = 1'b1;
          scl_out_next    = 1'b1;
          shift_byte_next = '0;
          bit_count_next  = '0;
          phase_next      = PH_RX_HIGH;
        end else begin
          wait_count_next = wait_inc;
        end
      end
      PH_RX_HIGH: begin
        if (!reached) begin
          wait_count_next = wait_inc;
        end else if (item.scl_in) begin
          wait_count_next = '0;
          shift_byte_next = {shift_byte[6:0], item.sda_in};
          bit_count_next  = bit_count + 4'd1;
          scl_out_next    = 1'b0;
          phase_next      = PH_RX_LOWBIT;
        end
      end
      PH_RX_LOWBIT: begin
        if (reached) begin
          wait_count_next = '0;
          if (bit_count[3]) begin
            // ack the first byte of a two-byte read, nack the last
            sda_out_next = (byte_step == 3'd3 && held_command == CMD_READ2) ? 1'b0 : 1'b1;
            phase_next   = PH_RA_SETUP;
          end else begin
            scl_out_next = 1'b1;
            phase_next   = PH_RX_HIGH;
          end
        end else begin
          wait_count_next = wait_inc;
        end
      end
      PH_RA_SETUP: begin
        if (reached) begin
          wait_count_next = '0;
          scl_out_next    = 1'b1;
          phase_next      = PH_RA_HIGH;
        end else begin
          wait_count_next = wait_inc;
        end
      end
      PH_RA_HIGH: begin
        if (!reached) begin
          wait_count_next = wait_inc;
        end else if (item.scl_in) begin
          wait_count_next = '0;
          scl_out_next    = 1'b0;
          phase_next      = PH_RA_LOW;
        end
      end
      PH_RA_LOW: begin
        if (reached) begin
          wait_count_next = '0;
          sda_out_next    = 1'b0;
          if (byte_step == 3'd3) begin
            gathered_data_next[7:0] = shift_byte;
          end else begin
            gathered_data_next[15:8] = shift_byte;
          end
          take_step = 1'b1;
        end else begin
          wait_count_next = wait_inc;
        end
      end
      PH_SP_RISE: begin
        if (item.scl_in) begin
          wait_count_next = '0;
          phase_next      = PH_SP_HOLD;
        end
      end
      PH_SP_HOLD: begin
        if (reached) begin
          wait_count_next = '0;
          sda_out_next    = 1'b1;
          phase_next      = PH_SP_BUF;
        end else begin
          wait_count_next = wait_inc;
        end
      end
      PH_SP_BUF: begin
        if (reached) begin
          wait_count_next = '0;
          done_next       = 1'b1;
          phase_next      = PH_IDLE;
        end else begin
          wait_count_next = wait_inc;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        scl_out_next    = 1'b1;
        sda_out_next    = 1'b1;
        wait_count_next = '0;
      end
    endcase

    // advance to the next byte of the transaction
    if (take_step) begin
      byte_step_next = step_inc;
      unique case (step_act)
        ACT_TX: begin
          shift_byte_next = tx_byte(step_inc, held_command, held_slave,
                                    held_register, held_write_byte);
          bit_count_next  = '0;
          phase_next      = PH_TX_LOW;
        end
        ACT_RESTART: begin
          scl_out_next = 1'b1;
          sda_out_next = 1'b1;
          phase_next   = PH_ST_SETUP;
        end
        ACT_RX: begin
          phase_next = PH_RX_LOW;
        end
        ACT_STOP: begin
          scl_out_next = 1'b1;
          phase_next   = PH_SP_RISE;
        end
        default: ;
      endcase
    end
  end

  // result of this tick, seen after the update
  always_comb begin
    result.scl_drive       = scl_out_next;
    result.sda_drive       = sda_out_next;
    result.busy_res        = (phase_next != PH_IDLE);
    result.done_res        = done_next;
    result.read_data       = gathered_data_next;
    result.err_nack        = error_bits_next[ERR_NACK_BIT];
    result.err_claim       = error_bits_next[ERR_CLAIM_BIT];
    result.err_arbitration = error_bits_next[ERR_ARB_BIT];
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      wait_count      <= '0;
      bit_count       <= '0;
      byte_step       <= '0;
      shift_byte      <= '0;
      gathered_data   <= '0;
      held_command    <= CMD_NONE;
      held_slave      <= '0;
      held_register   <= '0;
      held_write_byte <= '0;
      error_bits      <= '0;
      scl_out         <= 1'b1;
      sda_out         <= 1'b1;
    end else if (step_en) begin
      phase           <= phase_next;
      wait_count      <= wait_count_next;
      bit_count       <= bit_count_next;
      byte_step       <= byte_step_next;
      shift_byte      <= shift_byte_next;
      gathered_data   <= gathered_data_next;
      held_command    <= held_command_next;
      held_slave      <= held_slave_next;
      held_register   <= held_register_next;
      held_write_byte <= held_write_byte_next;
      error_bits      <= error_bits_next;
      scl_out         <= scl_out_next;
      sda_out         <= sda_out_next;
    end
  end

  // error flags only ever set
  `I2CM_ASSERT_NEXT(a_errors_sticky, clk, rst, 1'b1, (error_bits | $past(error_bits)) == error_bits)
  // a transaction in flight always holds a real command
  `I2CM_ASSERT_SAME(a_busy_has_command, clk, rst, phase != PH_IDLE, held_command != CMD_NONE)
  // the timer is parked at zero while idle
  `I2CM_ASSERT_SAME(a_idle_timer_clear, clk, rst, phase == PH_IDLE, wait_count == '0)

endmodule

// ----- src/i2c_master_register_access.sv -----
// ----------------------------------------------------------------------------
// i2c_master_register_access
// Open-drain I2C master for single and double register reads and writes.
// ----------------------------------------------------------------------------
// Each command item is one bus tick: sampled SDA/SCL plus an optional command.
// The block takes one item per clock while the result is not stalled and
// returns one result per item. An accepted item sits in the input register;
// when the result register is free or being emptied, the step logic updates
// the sequencer and loads its result into the result register. Throughput is
// one item per cycle without result stalls, set by the single-tick step logic
// between those two registers. A stalled result keeps the next item in the
// input register, and from then on the input stalls as long as the result does.
// All bus timings are tick counts from the timing registers; a count beyond
// the timer width saturates at the timer maximum.
// ----------------------------------------------------------------------------
module i2c_master_register_access #(
  parameter int TIMER_WIDTH = i2cm_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [i2cm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                 cmd_valid,
  output logic                                 cmd_ready,
  input  i2cm_pkg::cmd_item_t                  cmd_item,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output i2cm_pkg::res_item_t                  res_item
);
  import i2cm_pkg::*;

  timing_t   timing;
  cmd_item_t in_q;
  logic      in_full;
  res_item_t step_res;
  logic      advance;

  // timing registers
  i2cm_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .timing    (timing)
  );

  // the held item steps when the result slot is free or being emptied
  assign advance   = in_full && (!res_valid || res_ready);
  assign cmd_ready = !in_full || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (cmd_ready) begin
      in_full <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      in_q <= cmd_item;
    end
  end

  // bus sequencer
  i2cm_engine #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .item    (in_q),
    .timing  (timing),
    .result  (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_item <= step_res;
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the i2c register access master. A small bus model
// answers the master tick by tick (ack/nack, read bits, clock stretching,
// claim contention, arbitration noise), every tick is predicted in the bench
// and each returned tick result is compared field by field.
// ----------------------------------------------------------------------------
import i2cm_pkg::*;

// tracks predicted master state and the results still owed by the block
class i2c_bus_scoreboard;
  logic [15:0] regs [7];
  phase_t      phase;
  int unsigned wcnt;
  logic [3:0]  bit_count;
  logic [2:0]  byte_step;
  logic [7:0]  shift_byte;
  logic [15:0] gathered;
  logic [1:0]  held_cmd;
  logic [6:0]  held_slave;
  logic [7:0]  held_reg;
  logic [7:0]  held_wbyte;
  logic [2:0]  errs;
  logic        scl_out;
  logic        sda_out;
  res_item_t   pending_results[$];
  int          fails;

  function new();
    regs[CFG_HIGH_TIME]        = RST_HIGH_TIME;
    regs[CFG_LOW_TIME]         = RST_LOW_TIME;
    regs[CFG_START_SETUP_TIME] = RST_START_SETUP_TIME;
    regs[CFG_DATA_SETUP_TIME]  = RST_DATA_SETUP_TIME;
    regs[CFG_DATA_HOLD_TIME]   = RST_DATA_HOLD_TIME;
    regs[CFG_VALID_TIME]       = RST_VALID_TIME;
    regs[CFG_CLAIM_TIMEOUT]    = RST_CLAIM_TIMEOUT;
    phase = PH_IDLE;
    wcnt = 0;
    bit_count = '0;
    byte_step = '0;
    shift_byte = '0;
    gathered = '0;
    held_cmd = CMD_NONE;
    held_slave = '0;
    held_reg = '0;
    held_wbyte = '0;
    errs = '0;
    scl_out = 1'b1;
    sda_out = 1'b1;
    fails = 0;
  endfunction

  // delay of d ticks, finishing on tick d+1
  function bit timed(logic [15:0] d);
    if (wcnt >= d) begin
      wcnt = 0;
      return 1'b1;
    end
    wcnt++;
    return 1'b0;
  endfunction

  // same, then hold until scl reads high
  function bit timed_scl(logic [15:0] d, logic scl);
    if (wcnt >= d) begin
      if (scl) begin
        wcnt = 0;
        return 1'b1;
      end
      return 1'b0;
    end
    wcnt++;
    return 1'b0;
  endfunction

  function logic [7:0] tx_byte();
    if (byte_step == 3'd0) return {held_slave, 1'b0};
    if (byte_step == 3'd1) return held_reg;
    if (held_cmd == CMD_WRITE) return held_wbyte;
    return {held_slave, 1'b1};
  endfunction

  function void begin_tx();
    shift_byte = tx_byte();
    bit_count = '0;
    phase = PH_TX_LOW;
  endfunction

  function void begin_stop();
    scl_out = 1'b1;
    phase = PH_SP_RISE;
  endfunction

  // advance to the next byte of the transaction
  function void next_step();
    byte_step = byte_step + 3'd1;
    if (held_cmd == CMD_WRITE) begin
      if (byte_step <= 3'd2) begin_tx();
      else begin_stop();
      return;
    end
    if (byte_step == 3'd1) begin
      begin_tx();
    end else if (byte_step == 3'd2) begin
      scl_out = 1'b1;
      sda_out = 1'b1;
      phase = PH_ST_SETUP;
    end else if (byte_step == 3'd3 || (byte_step == 3'd4 && held_cmd == CMD_READ2)) begin
      phase = PH_RX_LOW;
    end else begin
      begin_stop();
    end
  endfunction

  // one accepted bus tick: update state and queue the expected result
  function void predict_tick(cmd_item_t it);
    logic      done;
    res_item_t r;
    done = 1'b0;
    case (phase)
      PH_IDLE: begin
        scl_out = 1'b1;
        sda_out = 1'b1;
        if (it.command != CMD_NONE) begin
          held_cmd = it.command;
          held_slave = it.device_addr;
          held_reg = it.reg_offset;
          held_wbyte = it.write_data;
          if (it.command != CMD_WRITE) gathered = '0;
          byte_step = '0;
          bit_count = '0;
          wcnt = 0;
          phase = PH_CLAIM_BUF;
        end
      end
      PH_CLAIM_BUF: begin
        if (timed(regs[CFG_LOW_TIME])) phase = PH_CLAIM_POLL;
      end
      PH_CLAIM_POLL: begin
        if (it.sda_in && it.scl_in) begin
          wcnt = 0;
          phase = PH_ST_SETUP;
        end else if (wcnt >= regs[CFG_CLAIM_TIMEOUT]) begin
          errs[ERR_CLAIM_BIT] = 1'b1;
          wcnt = 0;
          phase = PH_ST_SETUP;
        end else begin
          wcnt++;
        end
      end
      PH_ST_SETUP: begin
        if (timed(regs[CFG_START_SETUP_TIME])) begin
          sda_out = 1'b0;
          phase = PH_ST_HOLD;
        end
      end
      PH_ST_HOLD: begin
        if (timed(regs[CFG_HIGH_TIME])) begin
          scl_out = 1'b0;
          begin_tx();
        end
      end
      PH_TX_LOW: begin
        if (timed(regs[CFG_LOW_TIME])) begin
          sda_out = shift_byte[7];
          phase = PH_TX_SETUP;
        end
      end
      PH_TX_SETUP: begin
        if (timed(regs[CFG_DATA_SETUP_TIME])) begin
          scl_out = 1'b1;
          phase = PH_TX_HIGH;
        end
      end
      PH_TX_HIGH: begin
        // lost arbitration: a released one reads back low
        if (wcnt == 0 && shift_byte[7] && !it.sda_in) errs[ERR_ARB_BIT] = 1'b1;
        if (timed_scl(regs[CFG_HIGH_TIME], it.scl_in)) begin
          scl_out = 1'b0;
          shift_byte = shift_byte << 1;
          bit_count = bit_count + 4'd1;
          phase = PH_TX_HOLD;
        end
      end
      PH_TX_HOLD: begin
        if (timed(regs[CFG_DATA_HOLD_TIME])) begin
          if (bit_count >= 4'd8) begin
            sda_out = 1'b1;
            scl_out = 1'b1;
            phase = PH_ACK_VALID;
          end else begin
            sda_out = shift_byte[7];
            phase = PH_TX_SETUP;
          end
        end
      end
      PH_ACK_VALID: begin
        if (timed_scl(regs[CFG_VALID_TIME], it.scl_in)) begin
          if (it.sda_in) errs[ERR_NACK_BIT] = 1'b1;
          phase = PH_ACK_HIGH;
        end
      end
      PH_ACK_HIGH: begin
        if (timed(regs[CFG_HIGH_TIME])) begin
          scl_out = 1'b0;
          sda_out = 1'b0;
          next_step();
        end
      end
      PH_RX_LOW: begin
        if (timed(regs[CFG_LOW_TIME])) begin
          sda_out = 1'b1;
          scl_out = 1'b1;
          shift_byte = '0;
          bit_count = '0;
          phase = PH_RX_HIGH;
        end
      end
      PH_RX_HIGH: begin
        if (timed_scl(regs[CFG_VALID_TIME], it.scl_in)) begin
          shift_byte = {shift_byte[6:0], it.sda_in};
          bit_count = bit_count + 4'd1;
          scl_out = 1'b0;
          phase = PH_RX_LOWBIT;
        end
      end
      PH_RX_LOWBIT: begin
        if (timed(regs[CFG_LOW_TIME])) begin
          if (bit_count >= 4'd8) begin
            // ack the first byte of a double read, nack the last
            sda_out = (byte_step == 3'd3 && held_cmd == CMD_READ2) ? 1'b0 : 1'b1;
            phase = PH_RA_SETUP;
          end else begin
            scl_out = 1'b1;
            phase = PH_RX_HIGH;
          end
        end
      end
      PH_RA_SETUP: begin
        if (timed(regs[CFG_DATA_SETUP_TIME])) begin
          scl_out = 1'b1;
          phase = PH_RA_HIGH;
        end
      end
      PH_RA_HIGH: begin
        if (timed_scl(regs[CFG_HIGH_TIME], it.scl_in)) begin
          scl_out = 1'b0;
          phase = PH_RA_LOW;
        end
      end
      PH_RA_LOW: begin
        if (timed(regs[CFG_LOW_TIME])) begin
          sda_out = 1'b0;
          if (byte_step == 3'd3) gathered[7:0] = shift_byte;
          else gathered[15:8] = shift_byte;
          next_step();
        end
      end
      PH_SP_RISE: begin
        if (it.scl_in) begin
          wcnt = 0;
          phase = PH_SP_HOLD;
        end
      end
      PH_SP_HOLD: begin
        if (timed(regs[CFG_HIGH_TIME])) begin
          sda_out = 1'b1;
          phase = PH_SP_BUF;
        end
      end
      PH_SP_BUF: begin
        if (timed(regs[CFG_LOW_TIME])) begin
          done = 1'b1;
          phase = PH_IDLE;
        end
      end
      default: begin
        phase = PH_IDLE;
        scl_out = 1'b1;
        sda_out = 1'b1;
        wcnt = 0;
      end
    endcase
    r.scl_drive = scl_out;
    r.sda_drive = sda_out;
    r.busy_res = (phase != PH_IDLE);
    r.done_res = done;
    r.read_data = gathered;
    r.err_nack = errs[ERR_NACK_BIT];
    r.err_claim = errs[ERR_CLAIM_BIT];
    r.err_arbitration = errs[ERR_ARB_BIT];
    pending_results.push_back(r);
  endfunction

  function void cmp(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fails++;
    end
  endfunction

  // one returned result against the oldest expectation
  function void check_result(res_item_t got);
    res_item_t want;
    if (pending_results.size() == 0) begin
      $error("result with no transaction pending");
      fails++;
      return;
    end
    want = pending_results.pop_front();
    cmp("scl_drive", want.scl_drive, got.scl_drive);
    cmp("sda_drive", want.sda_drive, got.sda_drive);
    cmp("busy_res", want.busy_res, got.busy_res);
    cmp("done_res", want.done_res, got.done_res);
    cmp("read_data", want.read_data, got.read_data);
    cmp("err_nack", want.err_nack, got.err_nack);
    cmp("err_claim", want.err_claim, got.err_claim);
    cmp("err_arbitration", want.err_arbitration, got.err_arbitration);
  endfunction
endclass

module tb_top;
  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
  logic                       cmd_valid = 1'b0;
  logic                       cmd_ready;
  cmd_item_t                  cmd_item = '1;
  logic                       res_valid;
  logic                       res_ready = 1'b0;
  res_item_t                  res_item;

  i2c_bus_scoreboard sb;

  // idling and bus behavior knobs
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          stretch_on = 0;
  bit          noisy = 0;
  bit          hog_claim = 0;
  int          stretch_left = 0;
  logic        last_scl = 1'b1;
  int          counted = 0;
  logic [15:0] timing_set [7];

  i2c_master_register_access dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_item (cmd_item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_item (res_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // overall run limit
  initial begin
    #400000;
    $display("tb_top NOT OK");
    $finish;
  end

  // receiver stalls
  always @(negedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor both transaction channels
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) sb.check_result(res_item);
      if (cmd_valid && cmd_ready) sb.predict_tick(cmd_item);
    end
  end

  // bus model: line levels seen by the master on the next tick
  function automatic cmd_item_t bus_tick(logic [1:0] cmd, logic [6:0] sa, logic [7:0] ra,
                                         logic [7:0] wd);
    cmd_item_t it;
    logic      slave_sda;
    logic      line_scl;
    it.command = cmd;
    it.device_addr = sa;
    it.reg_offset = ra;
    it.write_data = wd;
    // slave stretches scl after the master releases it
    if (!sb.scl_out) stretch_left = 0;
    else if (!last_scl && stretch_on && $urandom_range(2) == 0) stretch_left = $urandom_range(1, 5);
    last_scl = sb.scl_out;
    line_scl = sb.scl_out && stretch_left == 0;
    if (stretch_left != 0) stretch_left--;
    slave_sda = 1'b1;
    case (sb.phase)
      PH_ACK_VALID: slave_sda = noisy && $urandom_range(7) == 0;
      PH_RX_HIGH:   slave_sda = 1'($urandom_range(1));
      PH_CLAIM_POLL: begin
        if (hog_claim || (noisy && $urandom_range(1) == 0)) begin
          slave_sda = 1'b0;
          line_scl = line_scl & 1'($urandom_range(1));
        end
      end
      PH_TX_HIGH:   slave_sda = !(noisy && $urandom_range(15) == 0);
      default:      slave_sda = !(noisy && $urandom_range(9) == 0);
    endcase
    it.sda_in = sb.sda_out & slave_sda;
    it.scl_in = line_scl;
    return it;
  endfunction

  // present one tick and wait for its transaction
  task automatic send_tick(cmd_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_item <= it;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_ticks(int n);
    repeat (n) send_tick(bus_tick(CMD_NONE, 7'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  // keep the bus going while the master is busy; commands here are ignored
  task automatic run_bus(int max_ticks);
    int n;
    n = 0;
    while (sb.phase != PH_IDLE && n < max_ticks) begin
      send_tick(bus_tick(2'($urandom_range(3)), 7'($urandom), 8'($urandom), 8'($urandom)));
      n++;
      counted++;
    end
  endtask

  task automatic transfer(logic [1:0] cmd, logic [6:0] sa, logic [7:0] ra, logic [7:0] wd);
    send_tick(bus_tick(cmd, sa, ra, wd));
    counted++;
    run_bus(32'h7fffffff);
  endtask

  // sender holds off until every result is back
  task automatic settle();
    cmd_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_timing(logic [15:0] h, logic [15:0] l, logic [15:0] ss,
                            logic [15:0] ds, logic [15:0] dh, logic [15:0] v,
                            logic [15:0] ct);
    timing_set[CFG_HIGH_TIME] = h;
    timing_set[CFG_LOW_TIME] = l;
    timing_set[CFG_START_SETUP_TIME] = ss;
    timing_set[CFG_DATA_SETUP_TIME] = ds;
    timing_set[CFG_DATA_HOLD_TIME] = dh;
    timing_set[CFG_VALID_TIME] = v;
    timing_set[CFG_CLAIM_TIMEOUT] = ct;
    for (int i = CFG_HIGH_TIME; i <= CFG_CLAIM_TIMEOUT; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= cfg_index_t'(i);
      cfg_data <= timing_set[i];
      sb.regs[i] = timing_set[i];
      @(negedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic logic [15:0] short_delay();
    return ($urandom_range(3) == 0) ? 16'($urandom_range(1, 3)) : 16'd0;
  endfunction

  // main sequence
  initial begin
    sb = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed: reset timings through claim and start setup, then minimum timings
    idle_ticks(2);
    send_tick(bus_tick(CMD_WRITE, 7'h7F, 8'hFF, 8'h00));
    run_bus(100);
    settle();
    set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_bus(32'h7fffffff);
    transfer(CMD_READ2, 7'h00, 8'h00, 8'hFF);
    idle_ticks(1);
    transfer(CMD_READ, 7'h55, 8'hAA, 8'h00);

    // random phases across idling modes, later ones with a misbehaving bus
    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      stretch_on = (p != 0);
      noisy = (p >= 2);
      set_timing(short_delay(), short_delay(), short_delay(), short_delay(),
                 short_delay(), short_delay(), 16'($urandom_range(0, 6)));
      counted = 0;
      while (counted < 60) begin
        idle_ticks($urandom_range(0, 3));
        transfer(2'($urandom_range(1, 3)), 7'($urandom), 8'($urandom), 8'($urandom));
      end
    end

    // all registers at maximum, then dropped to zero part way through
    settle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    stretch_on = 0;
    noisy = 0;
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(bus_tick(CMD_READ, 7'($urandom), 8'($urandom), 8'($urandom)));
    run_bus(20);
    settle();
    set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_bus(32'h7fffffff);

    // claim timeout with the bus held busy
    settle();
    hog_claim = 1;
    set_timing(16'd0, 16'd0, 16'd8, 16'd0, 16'd0, 16'd0, 16'd8);
    transfer(CMD_WRITE, 7'($urandom), 8'($urandom), 8'($urandom));
    hog_claim = 0;
    idle_ticks(3);

    settle();
    if (sb.fails == 0 && sb.pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
